// ===== hw/rtl/pss_pkg.sv =====
// Shared types, widths and helpers for the polyline spline smoother.
package pss_pkg;

  localparam int COORD_W = 24;            // Q15.8 coordinate
  localparam int MUL_A_W = COORD_W + 1;   // coordinate or coordinate difference
  localparam int MUL_B_W = 17;            // scale or weight, unsigned
  localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;
  localparam int DEN_W   = 10;            // 2*n*n up to 800
  localparam int STEP_W  = 5;             // segment step count
  localparam int DIV_QB  = COORD_W;       // quotient bits produced
  localparam int Q_W     = DIV_QB + 1;    // signed quotient
  localparam int D_W     = 26;            // rounded control offset
  localparam int SAT_W   = 27;            // widest value fed to saturation
  localparam int SCALE_W = 16;

  // largest step count per segment; DEN_W and STEP_W are sized for it
  localparam int MAX_SEGMENT_STEPS = 20;

  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_STEPS = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd16384;
  localparam logic [STEP_W-1:0]  STEPS_RST = 5'd10;

  // multiply-accumulate control
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  // divider control
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'(25'sd8388607));
    lo = -SAT_W'(signed'(25'sd8388608));
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return v[COORD_W-1:0];
  endfunction

  // divide by 2^16, round to nearest, ties away from zero
  function automatic logic signed [D_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r = (m + ACC_W'(32768)) >> 16;
    return v[ACC_W-1] ? -D_W'(r) : D_W'(r);
  endfunction

endpackage

// ===== hw/rtl/pss_mac.sv =====
// Shared multiply-accumulate unit: one product per cycle while enabled, into a register.
module pss_mac (
  input  logic                                clk,
  input  pss_pkg::mac_ctl_t                   ctl,
  input  logic signed [pss_pkg::MUL_A_W-1:0]  a,
  input  logic        [pss_pkg::MUL_B_W-1:0]  b,
  output logic signed [pss_pkg::ACC_W-1:0]    acc
);

  logic signed [pss_pkg::ACC_W-1:0] acc_r;
  logic signed [pss_pkg::ACC_W-1:0] acc_nxt;
  logic signed [pss_pkg::ACC_W-1:0] prod;

  // product of a signed operand and an unsigned weight
  assign prod = a * $signed({1'b0, b});

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = (ctl.clr ? '0 : acc_r) + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/pss_div.sv =====
// Iterative restoring divider with round-to-nearest, one quotient bit a cycle.
module pss_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pss_pkg::div_ctl_t                  ctl,
  input  logic signed [pss_pkg::ACC_W-1:0]   num,
  input  logic        [pss_pkg::DEN_W-1:0]   den,
  output logic                               busy,
  output logic                               done,
  output logic signed [pss_pkg::Q_W-1:0]     quo
);

  localparam int CNT_W = $clog2(pss_pkg::DIV_QB);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          neg_r, neg_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [pss_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [pss_pkg::DIV_QB-1:0]    sh_r, sh_nxt;
  logic [pss_pkg::ACC_W-1:0]     mag;
  logic [pss_pkg::DEN_W:0]       rem2;
  logic                          ge;

  // magnitude plus half the divisor; it stays below den * 2^DIV_QB
  assign mag  = (num[pss_pkg::ACC_W-1] ? pss_pkg::ACC_W'(-num) : pss_pkg::ACC_W'(num))
              + pss_pkg::ACC_W'(den >> 1);
  assign rem2 = {rem_r, sh_r[pss_pkg::DIV_QB-1]};
  assign ge   = rem2 >= {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[pss_pkg::ACC_W-1];
      cnt_nxt  = CNT_W'(pss_pkg::DIV_QB - 1);
      rem_nxt  = mag[pss_pkg::DIV_QB+pss_pkg::DEN_W-1:pss_pkg::DIV_QB];
      sh_nxt   = mag[pss_pkg::DIV_QB-1:0];
    end else if (busy_r) begin
      // trial subtract, quotient bit shifts in at the bottom
      rem_nxt = ge ? pss_pkg::DEN_W'(rem2 - {1'b0, den}) : rem2[pss_pkg::DEN_W-1:0];
      sh_nxt  = {sh_r[pss_pkg::DIV_QB-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, sh_r}) : $signed({1'b0, sh_r});

endmodule

// ===== hw/rtl/polyline_spline_smoother.sv =====
// Top level: vertex sequencer, control point state and output register.
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------
//  in      | in_tvalid in_tready in_tlast   | tdata: point_x, point_y; tlast: is_final
//  out     | out_tvalid out_tready out_tlast| tdata: out_x, out_y; tlast: run_end
//  cfg     | cfg_valid cfg_ready            | cfg_index, cfg_data
//
// Each curve sample takes three MAC steps and one pass through the shared divider
// (24 quotient bits) per coordinate, then the output write. One vertex yields from no
// samples (second vertex) up to 63 samples plus the vertex itself. in_tready is high
// only while the sequencer is idle; a stalled output holds the sequencer in its write
// step. Reset is synchronous and needs no clearing pass.
module polyline_spline_smoother (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // point_x[23:0], point_y[47:24]
  input  logic        in_tlast,    // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // out_x[23:0], out_y[47:24]
  output logic        out_tlast,   // run_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = pss_pkg::COORD_W;

  typedef enum logic [12:0] {
    ST_IDLE       = 13'b0000000000001,
    ST_EMIT_FIRST = 13'b0000000000010,
    ST_MUL_DX     = 13'b0000000000100,
    ST_MUL_DY     = 13'b0000000001000,
    ST_LOAD_E     = 13'b0000000010000,
    ST_PUSH       = 13'b0000000100000,
    ST_SMP_MAC    = 13'b0000001000000,
    ST_DIV_GO     = 13'b0000010000000,
    ST_DIV_WAIT   = 13'b0000100000000,
    ST_SMP_OUT    = 13'b0001000000000,
    ST_PUSH_DONE  = 13'b0010000000000,
    ST_EMIT_LAST  = 13'b0100000000000,
    ST_FINISH     = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_E     = 2'd1,
    PH_F     = 2'd2,
    PH_LASTV = 2'd3
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [pss_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic [pss_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [1:0] ctrls_r, ctrls_nxt;
  logic signed [CW-1:0] pa_x_r, pa_x_nxt, pa_y_r, pa_y_nxt;
  logic signed [CW-1:0] pb_x_r, pb_x_nxt, pb_y_r, pb_y_nxt;
  logic signed [CW-1:0] rc0_x_r, rc0_x_nxt, rc0_y_r, rc0_y_nxt;
  logic signed [CW-1:0] rc1_x_r, rc1_x_nxt, rc1_y_r, rc1_y_nxt;
  logic signed [CW-1:0] p_x_r, p_x_nxt, p_y_r, p_y_nxt;
  logic signed [CW-1:0] v_x_r, v_x_nxt, v_y_r, v_y_nxt;
  logic last_r, last_nxt;
  logic signed [pss_pkg::D_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [pss_pkg::STEP_W-1:0] k_r, k_nxt;
  logic [pss_pkg::DEN_W-1:0]  w0_r, w0_nxt, w2_r, w2_nxt;
  logic [1:0] j_r, j_nxt;
  logic crd_r, crd_nxt;
  logic signed [pss_pkg::Q_W-1:0] qx_r, qx_nxt;

  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic signed [CW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic [pss_pkg::STEP_W-1:0] n_eff, nk;
  logic [pss_pkg::DEN_W-1:0]  n_sq, den, w1;
  logic out_free;

  pss_pkg::mac_ctl_t mac_ctl;
  pss_pkg::div_ctl_t div_ctl;
  logic signed [pss_pkg::MUL_A_W-1:0] mac_a;
  logic        [pss_pkg::MUL_B_W-1:0] mac_b;
  logic signed [pss_pkg::ACC_W-1:0]   acc;
  logic signed [pss_pkg::Q_W-1:0]     quo;
  logic div_busy, div_done;
  logic signed [CW-1:0] cx, cy, coord_sel;
  logic [pss_pkg::DEN_W-1:0] w_sel;
  logic signed [pss_pkg::D_W-1:0] dy_now;

  pss_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  pss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (acc),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // effective step count and segment denominator
  always_comb begin
    if (steps_r == '0) begin
      n_eff = pss_pkg::STEP_W'(1);
    end else if (steps_r > pss_pkg::STEP_W'(pss_pkg::MAX_SEGMENT_STEPS)) begin
      n_eff = pss_pkg::STEP_W'(pss_pkg::MAX_SEGMENT_STEPS);
    end else begin
      n_eff = steps_r;
    end
  end

  assign n_sq     = pss_pkg::DEN_W'(n_eff * n_eff);
  assign den      = pss_pkg::DEN_W'({n_sq, 1'b0});
  assign w1       = den - w0_r - w2_r;
  assign nk       = n_eff - k_r;
  assign out_free = !out_valid_r || out_tready;
  assign dy_now   = pss_pkg::rnd16(acc);

  // window operand for the current MAC step
  always_comb begin
    case (j_r)
      2'd0:    begin cx = rc0_x_r; cy = rc0_y_r; w_sel = w0_r; end
      2'd1:    begin cx = rc1_x_r; cy = rc1_y_r; w_sel = w1;   end
      default: begin cx = p_x_r;   cy = p_y_r;   w_sel = w2_r; end
    endcase
    coord_sel = crd_r ? cy : cx;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    scale_nxt     = scale_r;
    steps_nxt     = steps_r;
    seen_nxt      = seen_r;
    ctrls_nxt     = ctrls_r;
    pa_x_nxt      = pa_x_r;
    pa_y_nxt      = pa_y_r;
    pb_x_nxt      = pb_x_r;
    pb_y_nxt      = pb_y_r;
    rc0_x_nxt     = rc0_x_r;
    rc0_y_nxt     = rc0_y_r;
    rc1_x_nxt     = rc1_x_r;
    rc1_y_nxt     = rc1_y_r;
    p_x_nxt       = p_x_r;
    p_y_nxt       = p_y_r;
    v_x_nxt       = v_x_r;
    v_y_nxt       = v_y_r;
    last_nxt      = last_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    k_nxt         = k_r;
    w0_nxt        = w0_r;
    w2_nxt        = w2_r;
    j_nxt         = j_r;
    crd_nxt       = crd_r;
    qx_nxt        = qx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;
    div_ctl       = '0;

    // register writes
    if (cfg_valid) begin
      case (cfg_index)
        pss_pkg::CFG_SCALE: scale_nxt = cfg_data;
        pss_pkg::CFG_STEPS: steps_nxt = cfg_data[pss_pkg::STEP_W-1:0];
        default:            scale_nxt = scale_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          v_x_nxt  = in_tdata[CW-1:0];
          v_y_nxt  = in_tdata[2*CW-1:CW];
          last_nxt = in_tlast;
          ctrls_nxt = (seen_r == 2'd0) ? 2'd0 : ((seen_r == 2'd3) ? 2'd2 : 2'd1);
          if (seen_r == 2'd0) begin
            state_nxt = ST_EMIT_FIRST;
          end else if (seen_r == 2'd1) begin
            if (in_tlast) begin
              p_x_nxt   = in_tdata[CW-1:0];
              p_y_nxt   = in_tdata[2*CW-1:CW];
              phase_nxt = PH_LASTV;
              state_nxt = ST_PUSH;
            end else begin
              state_nxt = ST_FINISH;
            end
          end else begin
            state_nxt = ST_MUL_DX;
          end
        end
      end
      ST_EMIT_FIRST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = v_x_r;
          out_y_nxt     = v_y_r;
          out_last_nxt  = !last_r;
          p_x_nxt       = v_x_r;
          p_y_nxt       = v_y_r;
          phase_nxt     = PH_FIRST;
          state_nxt     = ST_PUSH;
        end
      end
      ST_MUL_DX: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1};
        mac_a     = {pa_x_r[CW-1], pa_x_r} - {v_x_r[CW-1], v_x_r};
        mac_b     = pss_pkg::MUL_B_W'(scale_r);
        state_nxt = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        dx_nxt    = pss_pkg::rnd16(acc);
        mac_ctl   = '{en: 1'b1, clr: 1'b1};
        mac_a     = {pa_y_r[CW-1], pa_y_r} - {v_y_r[CW-1], v_y_r};
        mac_b     = pss_pkg::MUL_B_W'(scale_r);
        state_nxt = ST_LOAD_E;
      end
      ST_LOAD_E: begin
        dy_nxt    = dy_now;
        p_x_nxt   = pss_pkg::sat24(pss_pkg::SAT_W'(pb_x_r) + pss_pkg::SAT_W'(dx_r));
        p_y_nxt   = pss_pkg::sat24(pss_pkg::SAT_W'(pb_y_r) + pss_pkg::SAT_W'(dy_now));
        phase_nxt = PH_E;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (ctrls_r == 2'd2) begin
          k_nxt     = '0;
          w0_nxt    = n_sq;
          w2_nxt    = '0;
          j_nxt     = 2'd0;
          crd_nxt   = 1'b0;
          state_nxt = ST_SMP_MAC;
        end else begin
          state_nxt = ST_PUSH_DONE;
        end
      end
      ST_SMP_MAC: begin
        mac_ctl = '{en: 1'b1, clr: (j_r == 2'd0)};
        mac_a   = {coord_sel[CW-1], coord_sel};
        mac_b   = pss_pkg::MUL_B_W'(w_sel);
        if (j_r == 2'd2) begin
          state_nxt = ST_DIV_GO;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DIV_GO: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          j_nxt = 2'd0;
          if (!crd_r) begin
            qx_nxt    = quo;
            crd_nxt   = 1'b1;
            state_nxt = ST_SMP_MAC;
          end else begin
            state_nxt = ST_SMP_OUT;
          end
        end
      end
      ST_SMP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pss_pkg::sat24(pss_pkg::SAT_W'(qx_r));
          out_y_nxt     = pss_pkg::sat24(pss_pkg::SAT_W'(quo));
          out_last_nxt  = (k_r == n_eff) && (phase_r == PH_F) && !last_r;
          if (k_r == n_eff) begin
            state_nxt = ST_PUSH_DONE;
          end else begin
            // step the weights to the next parameter value
            w2_nxt    = w2_r + pss_pkg::DEN_W'({k_r, 1'b1});
            w0_nxt    = w0_r - pss_pkg::DEN_W'({nk, 1'b0}) + pss_pkg::DEN_W'(1);
            k_nxt     = k_r + 1'b1;
            j_nxt     = 2'd0;
            crd_nxt   = 1'b0;
            state_nxt = ST_SMP_MAC;
          end
        end
      end
      ST_PUSH_DONE: begin
        rc0_x_nxt = rc1_x_r;
        rc0_y_nxt = rc1_y_r;
        rc1_x_nxt = p_x_r;
        rc1_y_nxt = p_y_r;
        if (ctrls_r != 2'd2) ctrls_nxt = ctrls_r + 2'd1;
        case (phase_r)
          PH_E: begin
            p_x_nxt   = pss_pkg::sat24(pss_pkg::SAT_W'(pb_x_r) - pss_pkg::SAT_W'(dx_r));
            p_y_nxt   = pss_pkg::sat24(pss_pkg::SAT_W'(pb_y_r) - pss_pkg::SAT_W'(dy_r));
            phase_nxt = PH_F;
            state_nxt = ST_PUSH;
          end
          PH_LASTV: begin
            state_nxt = ST_EMIT_LAST;
          end
          default: begin
            if (last_r) begin
              p_x_nxt   = v_x_r;
              p_y_nxt   = v_y_r;
              phase_nxt = PH_LASTV;
              state_nxt = ST_PUSH;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
        endcase
      end
      ST_EMIT_LAST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = v_x_r;
          out_y_nxt     = v_y_r;
          out_last_nxt  = 1'b1;
          // polyline closed: back to the empty state
          seen_nxt  = 2'd0;
          pa_x_nxt  = '0;
          pa_y_nxt  = '0;
          pb_x_nxt  = '0;
          pb_y_nxt  = '0;
          rc0_x_nxt = '0;
          rc0_y_nxt = '0;
          rc1_x_nxt = '0;
          rc1_y_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: begin
        pa_x_nxt  = pb_x_r;
        pa_y_nxt  = pb_y_r;
        pb_x_nxt  = v_x_r;
        pb_y_nxt  = v_y_r;
        if (seen_r != 2'd3) seen_nxt = seen_r + 2'd1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FIRST;
      scale_r     <= pss_pkg::SCALE_RST;
      steps_r     <= pss_pkg::STEPS_RST;
      seen_r      <= 2'd0;
      ctrls_r     <= 2'd0;
      pa_x_r      <= '0;
      pa_y_r      <= '0;
      pb_x_r      <= '0;
      pb_y_r      <= '0;
      rc0_x_r     <= '0;
      rc0_y_r     <= '0;
      rc1_x_r     <= '0;
      rc1_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      scale_r     <= scale_nxt;
      steps_r     <= steps_nxt;
      seen_r      <= seen_nxt;
      ctrls_r     <= ctrls_nxt;
      pa_x_r      <= pa_x_nxt;
      pa_y_r      <= pa_y_nxt;
      pb_x_r      <= pb_x_nxt;
      pb_y_r      <= pb_y_nxt;
      rc0_x_r     <= rc0_x_nxt;
      rc0_y_r     <= rc0_y_nxt;
      rc1_x_r     <= rc1_x_nxt;
      rc1_y_r     <= rc1_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_x_r      <= p_x_nxt;
    p_y_r      <= p_y_nxt;
    v_x_r      <= v_x_nxt;
    v_y_r      <= v_y_nxt;
    last_r     <= last_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    k_r        <= k_nxt;
    w0_r       <= w0_nxt;
    w2_r       <= w2_nxt;
    j_r        <= j_nxt;
    crd_r      <= crd_nxt;
    qx_r       <= qx_nxt;
    out_last_r <= out_last_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // divider is never restarted while a division is in flight
  assert property (@(posedge clk) disable iff (!rst_n) div_ctl.start |-> !div_busy)
    else $error("divider started while busy");

  // control count saturates at two
  assert property (@(posedge clk) disable iff (!rst_n) ctrls_r != 2'd3)
    else $error("control count overflow");

  // sample index stays within the segment while sampling
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SMP_MAC || state_r == ST_SMP_OUT) |-> (k_r <= n_eff))
    else $error("sample index past segment end");

  // an idle sequencer leaves the divider idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

endmodule
